[hw/rtl/assert_macros.svh]
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[hw/rtl/mrs_pkg.sv]
`default_nettype none
package mrs_pkg;

	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] CFG_MAX_ADDR   = 2'd0;
	localparam logic [1:0] CFG_STATUS_IDX = 2'd1;
	localparam logic [1:0] CFG_MASK       = 2'd2;

	localparam logic [1:0] KIND_TX        = 2'd0;
	localparam logic [1:0] KIND_ADDR_DONE = 2'd1;
	localparam logic [1:0] KIND_DATA_REQ  = 2'd2;

	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam logic [7:0]  EXC_FLAG         = 8'h80;
	localparam logic [15:0] MAX_READ_CNT     = 16'd125;
	localparam logic [7:0]  EXC_ILLEGAL_FN   = 8'h01;
	localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
	localparam logic [7:0]  ADDR_UNASSIGNED  = 8'hFF;
	localparam logic [7:0]  ADDR_BROADCAST   = 8'h00;
	localparam logic [7:0]  FC_READ          = 8'h03;
	localparam logic [7:0]  FC_ASSIGN        = 8'h41;
	localparam logic [7:0]  FC_ADDR_DONE     = 8'h42;
	localparam logic [7:0]  FC_DATA_REQ      = 8'h43;
	localparam logic [7:0]  DATA_REQ_LIMIT   = 8'd4;
	localparam int          MIN_FRAME        = 4;
	localparam int          MIN_ASSIGN_FRAME = 5;
	localparam int          MIN_READ_FRAME   = 8;
	localparam int          HDR_BYTES        = 6;

	localparam logic [7:0] CFG_MAX_ADDR_RST   = 8'd247;
	localparam logic [3:0] CFG_STATUS_IDX_RST = 4'd0;
	localparam logic [15:0] CFG_MASK_RST      = 16'd1;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  rx_data;
		logic [7:0]  reg_index;
		logic [15:0] reg_value;
		logic        chain_eligible;
	} item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] tx_data;
		logic       last;
		logic [7:0] node_address;
	} result_t;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_TICK,
		OP_WRITE,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [7:0]  reg_index;
		logic [15:0] reg_value;
		logic        elig;
	} work_t;

	typedef struct packed {
		logic [7:0]  max_addr;
		logic [3:0]  status_idx;
		logic [15:0] mask;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_DRAIN,
		BK_EVAL,
		BK_TX,
		BK_EVENT
	} bk_state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/mrs_front.sv]
`default_nettype none
module mrs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mrs_pkg::item_t item,
	output logic                full,
	input  wire logic           take,
	output logic                work_valid,
	output mrs_pkg::work_t      work
);
	mrs_pkg::work_t q_q [2];
	logic [1:0] cnt_q;
	logic       wptr_q;
	logic       rptr_q;
	logic       do_push;
	logic       do_pop;
	mrs_pkg::work_t cls;

	// classify the incoming command
	always_comb begin
		cls.data      = item.rx_data;
		cls.reg_index = item.reg_index;
		cls.reg_value = item.reg_value;
		cls.elig      = item.chain_eligible;
		case (item.command)
			mrs_pkg::CMD_BYTE:  cls.op = mrs_pkg::OP_BYTE;
			mrs_pkg::CMD_TICK:  cls.op = mrs_pkg::OP_TICK;
			mrs_pkg::CMD_WRITE: cls.op = mrs_pkg::OP_WRITE;
			default:            cls.op = mrs_pkg::OP_NOP;
		endcase
	end

	assign full       = (cnt_q == 2'd2);
	assign work_valid = (cnt_q != 2'd0);
	assign work       = q_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = take && work_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wptr_q] <= cls;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/mrs_back.sv]
`default_nettype none
module mrs_back #(
	parameter int NUM_HOLDING = 16,
	parameter int RX_DEPTH    = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mrs_pkg::cfg_t  cfg,
	input  wire logic           work_valid,
	input  wire mrs_pkg::work_t work,
	output logic                work_take,
	input  wire logic           res_full,
	output logic                res_push,
	output mrs_pkg::result_t    res
);
	localparam int LW  = $clog2(RX_DEPTH + 1);
	localparam int AW  = $clog2(RX_DEPTH);
	localparam int HAW = (NUM_HOLDING > 1) ? $clog2(NUM_HOLDING) : 1;

	mrs_pkg::bk_state_t state_q, state_nxt;

	logic [7:0]  buf_mem [RX_DEPTH];
	logic [15:0] holding_q [NUM_HOLDING];
	logic [LW-1:0] len_q, flen_q, rd_ptr_q, didx_s1;
	logic        elig_q;
	logic [7:0]  rdat_s1;
	logic        dv_s1;
	logic [15:0] crc_q;
	logic [7:0]  p_hi_q, p_lo_q;
	logic [7:0]  f_q [mrs_pkg::HDR_BYTES];
	logic [7:0]  own_q;
	logic [7:0]  b0_q, b1_q, b2_q;
	logic [6:0]  ntx_q, tx_idx_q;
	logic [HAW-1:0] start_q;
	logic [15:0] txcrc_q;
	logic [1:0]  kind_q;

	// frame evaluation
	logic        crc_ok, ev_tx, ev_evt, ev_assign;
	logic [1:0]  ev_kind;
	logic [7:0]  ev_b0, ev_b1, ev_b2;
	logic [6:0]  ev_n;
	logic [15:0] rd_start, rd_cnt;
	logic [16:0] rd_end;
	logic        idle_take;

	always_comb begin
		crc_ok   = (flen_q >= LW'(mrs_pkg::MIN_FRAME)) && (crc_q == {p_hi_q, p_lo_q});
		rd_start = {f_q[2], f_q[3]};
		rd_cnt   = {f_q[4], f_q[5]};
		rd_end   = {1'b0, rd_start} + {1'b0, rd_cnt};
		ev_tx    = 1'b0;
		ev_evt   = 1'b0;
		ev_assign = 1'b0;
		ev_kind  = mrs_pkg::KIND_TX;
		ev_b0    = own_q;
		ev_b1    = f_q[1] | mrs_pkg::EXC_FLAG;
		ev_b2    = mrs_pkg::EXC_ILLEGAL_FN;
		ev_n     = 7'd3;
		if (crc_ok) begin
			if (f_q[0] == mrs_pkg::ADDR_BROADCAST) begin
				if (f_q[1] == mrs_pkg::FC_ASSIGN) begin
					if (flen_q >= LW'(mrs_pkg::MIN_ASSIGN_FRAME) && elig_q &&
						own_q == mrs_pkg::ADDR_UNASSIGNED && f_q[2] != 8'd0 &&
						f_q[2] <= cfg.max_addr) begin
						ev_assign = 1'b1;
						ev_tx     = 1'b1;
						ev_b0     = f_q[2];
						ev_b1     = mrs_pkg::FC_ASSIGN;
						ev_b2     = f_q[2];
					end
				end else if (f_q[1] == mrs_pkg::FC_ADDR_DONE) begin
					ev_evt  = 1'b1;
					ev_kind = mrs_pkg::KIND_ADDR_DONE;
				end
			end else if (f_q[0] == own_q) begin
				if (f_q[1] == mrs_pkg::FC_READ) begin
					if (flen_q >= LW'(mrs_pkg::MIN_READ_FRAME)) begin
						ev_tx = 1'b1;
						if (rd_cnt == 16'd0 || rd_cnt > mrs_pkg::MAX_READ_CNT ||
							rd_end > 17'(NUM_HOLDING)) begin
							ev_b2 = mrs_pkg::EXC_ILLEGAL_ADDR;
						end else begin
							ev_b1 = mrs_pkg::FC_READ;
							ev_b2 = {rd_cnt[6:0], 1'b0};
							ev_n  = 7'd3 + {rd_cnt[5:0], 1'b0};
						end
					end
				end else if (f_q[1] == mrs_pkg::FC_DATA_REQ) begin
					if (f_q[2] >= mrs_pkg::DATA_REQ_LIMIT) begin
						ev_tx = 1'b1;
						ev_b2 = mrs_pkg::EXC_ILLEGAL_ADDR;
					end else begin
						ev_evt  = 1'b1;
						ev_kind = mrs_pkg::KIND_DATA_REQ;
					end
				end else begin
					ev_tx = 1'b1;
				end
			end
		end
	end

	// response byte generation
	logic [6:0]  off;
	logic [HAW-1:0] widx;
	logic [15:0] word;
	logic [7:0]  tx_byte;
	logic        tx_last;

	always_comb begin
		off     = tx_idx_q - 7'd3;
		widx    = start_q + HAW'(off[6:1]);
		word    = holding_q[widx];
		tx_last = (tx_idx_q == ntx_q + 7'd1);
		if (tx_idx_q == 7'd0) begin
			tx_byte = b0_q;
		end else if (tx_idx_q == 7'd1) begin
			tx_byte = b1_q;
		end else if (tx_idx_q == 7'd2) begin
			tx_byte = b2_q;
		end else if (tx_idx_q < ntx_q) begin
			tx_byte = off[0] ? word[7:0] : word[15:8];
		end else if (tx_idx_q == ntx_q) begin
			tx_byte = txcrc_q[7:0];
		end else begin
			tx_byte = txcrc_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrs_pkg::BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		work_take = 1'b0;
		res_push  = 1'b0;
		res.result_kind  = kind_q;
		res.tx_data      = 8'd0;
		res.last         = 1'b1;
		res.node_address = own_q;
		case (state_q)
			mrs_pkg::BK_IDLE: begin
				if (work_valid) begin
					work_take = 1'b1;
					if (work.op == mrs_pkg::OP_TICK && len_q != '0) begin
						state_nxt = mrs_pkg::BK_READ;
					end
				end
			end
			mrs_pkg::BK_READ: begin
				if (rd_ptr_q == flen_q - LW'(1)) begin
					state_nxt = mrs_pkg::BK_DRAIN;
				end
			end
			mrs_pkg::BK_DRAIN: begin
				state_nxt = mrs_pkg::BK_EVAL;
			end
			mrs_pkg::BK_EVAL: begin
				if (ev_tx) begin
					state_nxt = mrs_pkg::BK_TX;
				end else if (ev_evt) begin
					state_nxt = mrs_pkg::BK_EVENT;
				end else begin
					state_nxt = mrs_pkg::BK_IDLE;
				end
			end
			mrs_pkg::BK_TX: begin
				res.result_kind = mrs_pkg::KIND_TX;
				res.tx_data     = tx_byte;
				res.last        = tx_last;
				res_push        = !res_full;
				if (!res_full && tx_last) begin
					state_nxt = mrs_pkg::BK_IDLE;
				end
			end
			mrs_pkg::BK_EVENT: begin
				res_push = !res_full;
				if (!res_full) begin
					state_nxt = mrs_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nxt = mrs_pkg::BK_IDLE;
			end
		endcase
	end

	assign idle_take = (state_q == mrs_pkg::BK_IDLE) && work_valid;

	// frame buffer
	always_ff @(posedge clk) begin
		if (idle_take && work.op == mrs_pkg::OP_BYTE && len_q < LW'(RX_DEPTH)) begin
			buf_mem[len_q[AW-1:0]] <= work.data;
		end
	end

	always_ff @(posedge clk) begin
		rdat_s1 <= buf_mem[rd_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			own_q <= mrs_pkg::ADDR_UNASSIGNED;
			dv_s1 <= 1'b0;
			for (int i = 0; i < NUM_HOLDING; i++) begin
				holding_q[i] <= 16'd0;
			end
		end else begin
			dv_s1 <= (state_q == mrs_pkg::BK_READ);
			if (idle_take) begin
				case (work.op)
					mrs_pkg::OP_BYTE: begin
						if (len_q < LW'(RX_DEPTH)) begin
							len_q <= len_q + LW'(1);
						end
					end
					mrs_pkg::OP_WRITE: begin
						if (32'(work.reg_index) < NUM_HOLDING) begin
							holding_q[HAW'(work.reg_index)] <= work.reg_value;
						end
					end
					mrs_pkg::OP_TICK: begin
						len_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == mrs_pkg::BK_EVAL && ev_assign) begin
				own_q <= f_q[2];
				if (32'(cfg.status_idx) < NUM_HOLDING) begin
					holding_q[HAW'(cfg.status_idx)] <=
						holding_q[HAW'(cfg.status_idx)] | cfg.mask;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (idle_take && work.op == mrs_pkg::OP_TICK) begin
			flen_q   <= len_q;
			elig_q   <= work.elig;
			rd_ptr_q <= '0;
			crc_q    <= mrs_pkg::CRC_INIT;
		end
		if (state_q == mrs_pkg::BK_READ) begin
			rd_ptr_q <= rd_ptr_q + LW'(1);
		end
		didx_s1 <= rd_ptr_q;
		if (dv_s1) begin
			p_hi_q <= rdat_s1;
			p_lo_q <= p_hi_q;
			if ({1'b0, didx_s1} + (LW + 1)'(2) < {1'b0, flen_q}) begin
				crc_q <= mrs_pkg::crc_byte(crc_q, rdat_s1);
			end
			if (didx_s1 < LW'(mrs_pkg::HDR_BYTES)) begin
				f_q[didx_s1[2:0]] <= rdat_s1;
			end
		end
		if (state_q == mrs_pkg::BK_EVAL) begin
			b0_q     <= ev_b0;
			b1_q     <= ev_b1;
			b2_q     <= ev_b2;
			ntx_q    <= ev_n;
			start_q  <= HAW'(rd_start);
			kind_q   <= ev_kind;
			tx_idx_q <= 7'd0;
			txcrc_q  <= mrs_pkg::CRC_INIT;
		end
		if (state_q == mrs_pkg::BK_TX && !res_full) begin
			tx_idx_q <= tx_idx_q + 7'd1;
			if (tx_idx_q < ntx_q) begin
				txcrc_q <= mrs_pkg::crc_byte(txcrc_q, tx_byte);
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/mrs_outq.sv]
`default_nettype none
module mrs_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire mrs_pkg::result_t din,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output mrs_pkg::result_t      dout
);
	mrs_pkg::result_t q_q [4];
	logic [2:0] cnt_q;
	logic [1:0] wptr_q, rptr_q;
	logic do_wr, do_pop;

	assign full   = (cnt_q == 3'd4);
	assign empty  = (cnt_q == 3'd0);
	assign dout   = q_q[rptr_q];
	assign do_wr  = wr && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, do_wr} - {2'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			q_q[wptr_q] <= din;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/modbus_rtu_slave_frame_engine.sv]
// channel   | handshake           | payload
// item      | push / full         | item (command, rx_data, reg_index, reg_value, chain_eligible)
// result    | pop / empty         | result (result_kind, tx_data, last, node_address)
// config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// byte, local write and no-op items are taken by the back end from the input queue while it is idle
// a silence tick on a non-empty frame makes the back end walk the buffer for crc,
// then one cycle per result beat from the response sequencer while the result queue is not full
// buffer memory read port sets the walk, one byte per cycle
// reset clears control state and the holding registers at once, no clearing pass
// a full result queue stalls the sequencer, input queue keeps taking items until full
`default_nettype none
module modbus_rtu_slave_frame_engine #(
	parameter int NUM_HOLDING = 16,
	parameter int RX_DEPTH    = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mrs_pkg::item_t   item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output mrs_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);
	mrs_pkg::cfg_t    cfg_q;
	mrs_pkg::work_t   work;
	mrs_pkg::result_t res;
	logic work_valid, work_take, res_full, res_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_addr   <= mrs_pkg::CFG_MAX_ADDR_RST;
			cfg_q.status_idx <= mrs_pkg::CFG_STATUS_IDX_RST;
			cfg_q.mask       <= mrs_pkg::CFG_MASK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mrs_pkg::CFG_MAX_ADDR:   cfg_q.max_addr   <= cfg_data[7:0];
				mrs_pkg::CFG_STATUS_IDX: cfg_q.status_idx <= cfg_data[3:0];
				mrs_pkg::CFG_MASK:       cfg_q.mask       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.take       (work_take),
		.work_valid (work_valid),
		.work       (work)
	);

	mrs_back #(
		.NUM_HOLDING (NUM_HOLDING),
		.RX_DEPTH    (RX_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.work_valid (work_valid),
		.work       (work),
		.work_take  (work_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	mrs_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);
endmodule
`default_nettype wire

[hw/rtl/mrs_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module mrs_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             pop,
	input wire logic             empty,
	input wire mrs_pkg::result_t result
);
	logic is_event;
	assign is_event = !empty && (result.result_kind == mrs_pkg::KIND_ADDR_DONE ||
		result.result_kind == mrs_pkg::KIND_DATA_REQ);

	`ASSERT_IMPLY(a_event_last, clk, arst_n, is_event, result.last)
	`ASSERT_IMPLY(a_event_no_data, clk, arst_n, is_event, result.tx_data == 8'd0)
	`ASSERT_IMPLY(a_kind_valid, clk, arst_n, !empty, result.result_kind <= mrs_pkg::KIND_DATA_REQ)
	`ASSERT_NEXT(a_beat_held, clk, arst_n, !empty && !pop, !empty)
endmodule

bind modbus_rtu_slave_frame_engine mrs_checker u_mrs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
`default_nettype wire
